@@ rtl/rgb_histogram_contrast_stretch_top_defines.svh @@
// Assertion helpers shared by the checker.
`ifndef RGB_HISTOGRAM_CONTRAST_STRETCH_TOP_DEFINES_SVH
`define RGB_HISTOGRAM_CONTRAST_STRETCH_TOP_DEFINES_SVH

// Same-cycle implication.
`define RHCS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define RHCS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/rhcs_pkg.sv @@
package rhcs_pkg;

  localparam int unsigned CountW    = 23;
  localparam int unsigned SampleW   = 8;
  localparam int unsigned Bins      = 256;
  localparam int unsigned ClipW     = 16;
  localparam int unsigned ProdW     = ClipW + CountW;
  localparam int unsigned InDataW   = 24;
  localparam int unsigned OutDataW  = 40;
  localparam int unsigned ApbAddrW  = 3;

  localparam logic [CountW-1:0] MaxPixels = 23'd4194304;

  localparam logic [1:0] ReqClear  = 2'd0;
  localparam logic [1:0] ReqAccum  = 2'd1;
  localparam logic [1:0] ReqBounds = 2'd2;
  localparam logic [1:0] ReqMap    = 2'd3;

  localparam logic [SampleW-1:0] SampleMax = 8'd255;

endpackage

@@ rtl/rgb_histogram_contrast_stretch_top.sv @@
// Channel   Dir  Payload
// s_*       in   tuser: req_type; tdata: red_in, green_in, blue_in
// m_*       out  tuser: full_res; tdata: red/green/blue_out, low/high_bound
// apb       in   register 0 (addr 0): clip_fraction
// Accumulate passes through S_ACC to the output state, or goes straight to it when refused;
// map runs a bit-serial divide of 16 steps before the output state; clear runs the clearing pass.
// Clear and reset run a clearing pass over all 256 bins; input is held off meanwhile.
// Bounds reads and then evaluates each visited bin, at most 256 bins per channel.
// One transaction is in work at a time; a stalled output holds the sequencer in its output state.
module rgb_histogram_contrast_stretch_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [rhcs_pkg::InDataW-1:0]       s_tdata,   // red_in, green_in, blue_in
  input  logic [1:0]                         s_tuser,   // req_type
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [rhcs_pkg::OutDataW-1:0]      m_tdata,   // red, green, blue, low, high
  output logic                               m_tuser,   // full_res
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rhcs_pkg::ApbAddrW-1:0]      paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ACC    = 4'd1;
  localparam logic [3:0] S_MUL    = 4'd2;
  localparam logic [3:0] S_F_RD   = 4'd3;
  localparam logic [3:0] S_F_EV   = 4'd4;
  localparam logic [3:0] S_B_RD   = 4'd5;
  localparam logic [3:0] S_B_EV   = 4'd6;
  localparam logic [3:0] S_CH_END = 4'd7;
  localparam logic [3:0] S_M_DIV  = 4'd8;
  localparam logic [3:0] S_M_END  = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;
  localparam logic [3:0] S_CLR    = 4'd11;

  logic [3:0]                        state;
  logic [rhcs_pkg::CountW-1:0]       hist [3][rhcs_pkg::Bins];
  logic [rhcs_pkg::CountW-1:0]       q [3];
  logic [7:0]                        ra [3];
  logic [7:0]                        smp [3];
  logic [7:0]                        in_smp [3];
  logic [rhcs_pkg::CountW-1:0]       pcount;
  logic [rhcs_pkg::ClipW-1:0]        clip;
  logic [7:0]                        slo, shi;
  logic [rhcs_pkg::ProdW-1:0]        prod;
  logic [1:0]                        ch;
  logic [7:0]                        idx, chlo, chhi, glo, ghi, mlo, mhi;
  logic                              chok, any_ok;
  logic [rhcs_pkg::CountW-1:0]       removed;
  logic [rhcs_pkg::CountW-1:0]       h;
  logic [rhcs_pkg::CountW:0]         sum;
  logic                              pass;
  logic [7:0]                        res_col [3];
  logic                              res_full;
  logic [15:0]                       dvd [3];
  logic [7:0]                        rem [3];
  logic [2:0]                        zero;
  logic [3:0]                        cnt;
  logic [7:0]                        span;
  logic                              acc_we;
  logic                              clr_we;
  logic                              clr_rsp;

  assign in_smp[0] = s_tdata[7:0];
  assign in_smp[1] = s_tdata[15:8];
  assign in_smp[2] = s_tdata[23:16];

  assign s_tready = (state == S_IDLE);
  assign pready   = 1'b1;
  assign prdata   = {16'b0, clip};
  assign span     = shi - slo;
  assign acc_we   = (state == S_ACC);
  assign clr_we   = (state == S_CLR);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ra[c] = (state == S_IDLE) ? in_smp[c] : idx;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      if (acc_we) begin
        hist[c][smp[c]] <= q[c] + 1'b1;
      end else if (clr_we) begin
        hist[c][idx] <= '0;
      end
      q[c] <= hist[c][ra[c]];
    end
  end

  assign h    = q[ch];
  assign sum  = {1'b0, removed} + {1'b0, h};
  assign pass = sum <= {1'b0, prod[rhcs_pkg::ProdW-1:rhcs_pkg::ClipW]};
  assign mlo  = (chok && chlo < glo) ? chlo : glo;
  assign mhi  = (chok && chhi > ghi) ? chhi : ghi;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      idx      <= '0;
      clr_rsp  <= 1'b0;
      pcount   <= '0;
      clip     <= '0;
      slo      <= '0;
      shi      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (psel && penable && pwrite && !paddr[2]) begin
        clip <= pwdata[rhcs_pkg::ClipW-1:0];
      end
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            for (int c = 0; c < 3; c++) begin
              smp[c]     <= in_smp[c];
              res_col[c] <= '0;
            end
            res_full <= 1'b0;
            unique case (s_tuser)
              rhcs_pkg::ReqClear: begin
                pcount  <= '0;
                idx     <= '0;
                clr_rsp <= 1'b1;
                state   <= S_CLR;
              end
              rhcs_pkg::ReqAccum: begin
                if (pcount >= rhcs_pkg::MaxPixels) begin
                  res_full <= 1'b1;
                  state    <= S_OUT;
                end else begin
                  state <= S_ACC;
                end
              end
              rhcs_pkg::ReqBounds: begin
                state <= S_MUL;
              end
              default: begin
                for (int c = 0; c < 3; c++) begin
                  zero[c] <= (shi <= slo) || (in_smp[c] < slo);
                  dvd[c]  <= {in_smp[c] - slo, 8'b0} - {8'b0, in_smp[c] - slo};
                  rem[c]  <= '0;
                end
                cnt   <= 4'd15;
                state <= S_M_DIV;
              end
            endcase
          end
        end
        S_CLR: begin
          idx <= idx + 1'b1;
          if (idx == rhcs_pkg::SampleMax) begin
            state <= clr_rsp ? S_OUT : S_IDLE;
          end
        end
        S_ACC: begin
          pcount <= pcount + 1'b1;
          state  <= S_OUT;
        end
        S_MUL: begin
          prod    <= rhcs_pkg::ProdW'(clip) * rhcs_pkg::ProdW'(pcount);
          ch      <= '0;
          idx     <= '0;
          removed <= '0;
          any_ok  <= 1'b0;
          glo     <= rhcs_pkg::SampleMax;
          ghi     <= '0;
          state   <= S_F_RD;
        end
        S_F_RD: begin
          state <= S_F_EV;
        end
        S_F_EV: begin
          if (pass) begin
            removed <= sum[rhcs_pkg::CountW-1:0];
            if (idx == rhcs_pkg::SampleMax) begin
              chok  <= 1'b0;
              state <= S_CH_END;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_F_RD;
            end
          end else begin
            chlo    <= idx;
            chok    <= 1'b1;
            removed <= '0;
            if (idx == rhcs_pkg::SampleMax) begin
              chhi  <= idx;
              state <= S_CH_END;
            end else begin
              idx   <= rhcs_pkg::SampleMax;
              state <= S_B_RD;
            end
          end
        end
        S_B_RD: begin
          state <= S_B_EV;
        end
        S_B_EV: begin
          if (pass) begin
            removed <= sum[rhcs_pkg::CountW-1:0];
            if (idx - 1'b1 > chlo) begin
              idx   <= idx - 1'b1;
              state <= S_B_RD;
            end else begin
              chhi  <= chlo;
              state <= S_CH_END;
            end
          end else begin
            chhi  <= idx;
            state <= S_CH_END;
          end
        end
        S_CH_END: begin
          if (chok) begin
            any_ok <= 1'b1;
            glo    <= mlo;
            ghi    <= mhi;
          end
          if (ch == 2'd2) begin
            slo   <= (any_ok || chok) ? mlo : '0;
            shi   <= (any_ok || chok) ? mhi : '0;
            state <= S_OUT;
          end else begin
            ch      <= ch + 1'b1;
            idx     <= '0;
            removed <= '0;
            state   <= S_F_RD;
          end
        end
        S_M_DIV: begin
          for (int c = 0; c < 3; c++) begin
            if ({rem[c], dvd[c][15]} >= {1'b0, span}) begin
              rem[c] <= 8'({rem[c], dvd[c][15]} - {1'b0, span});
              dvd[c] <= {dvd[c][14:0], 1'b1};
            end else begin
              rem[c] <= {rem[c][6:0], dvd[c][15]};
              dvd[c] <= {dvd[c][14:0], 1'b0};
            end
          end
          cnt <= cnt - 1'b1;
          if (cnt == 4'd0) begin
            state <= S_M_END;
          end
        end
        S_M_END: begin
          for (int c = 0; c < 3; c++) begin
            if (zero[c]) begin
              res_col[c] <= '0;
            end else if (dvd[c][15:8] != 8'd0) begin
              res_col[c] <= rhcs_pkg::SampleMax;
            end else begin
              res_col[c] <= dvd[c][7:0];
            end
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {shi, slo, res_col[2], res_col[1], res_col[0]};
            m_tuser  <= res_full;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/rhcs_chk.sv @@
`include "rgb_histogram_contrast_stretch_top_defines.svh"

module rhcs_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [rhcs_pkg::OutDataW-1:0] m_tdata,
  input logic                          m_tuser
);

  `RHCS_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid, "output dropped while stalled")
  `RHCS_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready, "input taken while busy")
  `RHCS_ASSERT_NOW(a_full_no_color, clk, rst, m_tvalid && m_tuser, m_tdata[23:0] == 24'd0, "refused accumulate carries samples")
  `RHCS_ASSERT_NOW(a_bound_order, clk, rst, m_tvalid, m_tdata[31:24] <= m_tdata[39:32], "low bound above high bound")

endmodule

bind rgb_histogram_contrast_stretch_top rhcs_chk u_rhcs_chk (.*);
